/* hw/rtl/mrd_pkg.sv */
// Shared types and constants of the MQTT receive deframer.
package mrd_pkg;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_WIDTH        = 28;
    localparam int LEN_COUNT_WIDTH  = 3;
    localparam int TOPIC_WIDTH      = 16;
    localparam int LEN_GROUP_BITS   = 7;

    localparam logic [3:0] PKT_CONNACK = 4'd2;
    localparam logic [3:0] PKT_PUBLISH = 4'd3;

    localparam logic [2:0] CODE_UNKNOWN  = 3'd6;
    localparam logic [7:0] CODE_LAST_STD = 8'd5;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_BAD    = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_TYPE    = 3'd0,
        KIND_LEN     = 3'd1,
        KIND_TOPIC   = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_OTHER   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  packet_type;
        logic [7:0]  data_byte;
        logic        last_in_packet;
        logic        connack_event;
        logic [2:0]  connack_code;
        logic        malformed;
    } t_result;

endpackage

/* hw/rtl/mrd_in_if.sv */
// Input byte channel of the deframer.
interface mrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/mrd_out_if.sv */
// Tagged byte channel of the deframer.
interface mrd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_kind;
    logic [3:0] packet_type;
    logic [7:0] data_byte;
    logic       last_in_packet;
    logic       connack_event;
    logic [2:0] connack_code;
    logic       malformed;

    modport source (output valid, output byte_kind, output packet_type, output data_byte,
                    output last_in_packet, output connack_event, output connack_code,
                    output malformed, input ready);
    modport sink   (input valid, input byte_kind, input packet_type, input data_byte,
                    input last_in_packet, input connack_event, input connack_code,
                    input malformed, output ready);
endinterface

/* hw/rtl/mrd_parser.sv */
// Packet state of the deframer and the per-byte tagging logic.
module mrd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output mrd_pkg::t_result o_res
);
    import mrd_pkg::*;

    t_phase                     r_phase,     n_phase;
    logic [3:0]                 r_type,      n_type;
    logic [3:0]                 r_flags,     n_flags;
    logic [LEN_WIDTH-1:0]       r_remaining, n_remaining;
    logic [LEN_COUNT_WIDTH-1:0] r_len_count, n_len_count;
    logic [LEN_WIDTH-1:0]       r_body_idx,  n_body_idx;
    logic [TOPIC_WIDTH-1:0]     r_topic_len, n_topic_len;
    logic                       r_pub_ok,    n_pub_ok;

    logic [LEN_WIDTH-1:0] w_len_add;
    logic [4:0]           w_shift;
    logic [LEN_WIDTH-1:0] w_rem_m1;
    logic [LEN_WIDTH-1:0] w_offset;
    logic [LEN_WIDTH:0]   w_diff;
    logic [TOPIC_WIDTH-1:0] w_topic_full;
    logic                 w_qos;

    assign w_shift      = 5'(r_len_count[1:0]) * 5'(LEN_GROUP_BITS);
    assign w_len_add    = LEN_WIDTH'(i_byte[6:0]) << w_shift;
    assign w_rem_m1     = r_remaining - LEN_WIDTH'(1);
    assign w_offset     = r_body_idx - LEN_WIDTH'(2);
    assign w_diff       = {1'b0, w_offset} - (LEN_WIDTH+1)'(r_topic_len);
    assign w_topic_full = {r_topic_len[15:8], i_byte};
    assign w_qos        = (r_flags[2:1] != 2'd0);

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_flags     = r_flags;
        n_remaining = r_remaining;
        n_len_count = r_len_count;
        n_body_idx  = r_body_idx;
        n_topic_len = r_topic_len;
        n_pub_ok    = r_pub_ok;

        o_res                = '0;
        o_res.kind           = KIND_OTHER;
        o_res.data_byte      = i_byte;

        case (r_phase)
            PH_HEADER: begin
                n_type      = i_byte[7:4];
                n_flags     = i_byte[3:0];
                n_remaining = '0;
                n_len_count = '0;
                n_body_idx  = '0;
                n_topic_len = '0;
                n_pub_ok    = 1'b0;
                n_phase     = PH_LENGTH;
                o_res.kind  = KIND_TYPE;
            end
            PH_LENGTH: begin
                o_res.kind  = KIND_LEN;
                n_remaining = r_remaining + w_len_add;
                n_len_count = r_len_count + LEN_COUNT_WIDTH'(1);
                if (!i_byte[7]) begin
                    n_body_idx = '0;
                    if (n_remaining == '0) begin
                        o_res.last_in_packet = 1'b1;
                        n_phase              = PH_HEADER;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else if (n_len_count >= LEN_COUNT_WIDTH'(MAX_LENGTH_BYTES)) begin
                    n_phase = PH_BAD;
                end
            end
            PH_BODY: begin
                if (r_type == PKT_CONNACK) begin
                    if (r_body_idx == LEN_WIDTH'(1)) begin
                        o_res.connack_event = 1'b1;
                        o_res.connack_code  = (i_byte <= CODE_LAST_STD) ? i_byte[2:0]
                                                                        : CODE_UNKNOWN;
                    end
                end else if (r_type == PKT_PUBLISH) begin
                    if (r_body_idx == '0) begin
                        n_topic_len = {i_byte, 8'h00};
                    end else if (r_body_idx == LEN_WIDTH'(1)) begin
                        n_topic_len = w_topic_full;
                        n_pub_ok    = (w_rem_m1 >= LEN_WIDTH'(w_topic_full));
                    end else if (r_pub_ok) begin
                        if (w_diff[LEN_WIDTH]) begin
                            o_res.kind = KIND_TOPIC;
                        // packet id follows the topic when QoS is nonzero
                        end else if (!(w_qos && (w_diff[LEN_WIDTH-1:0] < LEN_WIDTH'(2)))) begin
                            o_res.kind = KIND_PAYLOAD;
                        end
                    end
                end
                n_remaining = w_rem_m1;
                n_body_idx  = r_body_idx + LEN_WIDTH'(1);
                if (w_rem_m1 == '0) begin
                    o_res.last_in_packet = 1'b1;
                    n_phase              = PH_HEADER;
                end
            end
            default: begin
                o_res.kind = KIND_OTHER;
            end
        endcase

        o_res.packet_type = n_type;
        o_res.malformed   = (n_phase == PH_BAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_type      <= '0;
            r_flags     <= '0;
            r_remaining <= '0;
            r_len_count <= '0;
            r_body_idx  <= '0;
            r_topic_len <= '0;
            r_pub_ok    <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_flags     <= n_flags;
            r_remaining <= n_remaining;
            r_len_count <= n_len_count;
            r_body_idx  <= n_body_idx;
            r_topic_len <= n_topic_len;
            r_pub_ok    <= n_pub_ok;
        end
    end

    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BAD) |=> (r_phase == PH_BAD))
        else $error("left malformed phase without reset");

    a_last_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.last_in_packet) |=> (r_phase == PH_HEADER))
        else $error("packet end did not return to header phase");

    a_connack_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.connack_event |-> (r_type == PKT_CONNACK && r_phase == PH_BODY))
        else $error("return code reported outside a CONNACK body");

    a_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LENGTH) |-> (r_len_count < LEN_COUNT_WIDTH'(MAX_LENGTH_BYTES)))
        else $error("length byte count overran in length phase");

endmodule

/* hw/rtl/mqtt_receive_deframer_top.sv */
// Top level of the MQTT 3.1.1 receive deframer: input and result registers.
//
// One received byte enters per transfer on i_in and one tagged byte leaves per transfer
// on o_out, in order. Each byte waits in the input register until the result register can
// take it and then sits in the result register until taken; the block sustains one byte
// per cycle while o_out.ready is high. The packet state update for a byte happens in the
// cycle in which it moves from the input register to the result register. A length field
// with a continuation bit on its fourth byte sets a sticky malformed state that only reset
// clears; from then on every byte is tagged as other with malformed set.
module mqtt_receive_deframer_top (
    input  logic i_clk,
    input  logic i_rst_n,
    mrd_in_if.sink    i_in,
    mrd_out_if.source o_out
);
    import mrd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    mrd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.byte_kind      = r_out.kind;
    assign o_out.packet_type    = r_out.packet_type;
    assign o_out.data_byte      = r_out.data_byte;
    assign o_out.last_in_packet = r_out.last_in_packet;
    assign o_out.connack_event  = r_out.connack_event;
    assign o_out.connack_code   = r_out.connack_code;
    assign o_out.malformed      = r_out.malformed;

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("staged byte lost while result register stalled");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("result dropped without a transfer");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out_valid && r_out.data_byte == $past(r_in_byte)))
        else $error("result register did not take the staged byte");

endmodule

/* tb/mqtt_receive_deframer_top_tb.sv */
// Testbench of the MQTT receive deframer: packet streams checked byte by byte against a predictor.
module mqtt_receive_deframer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrd_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int DRAIN_EVERY   = 600;
    localparam int MAX_GAP       = 10;
    localparam int STUCK_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 40;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk;
    logic i_rst_n;

    mrd_in_if  in_if();
    mrd_out_if out_if();

    mqtt_receive_deframer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state, reset values
    t_phase      ph        = PH_HEADER;
    logic [3:0]  cur_type  = '0;
    logic [3:0]  hdr_flags = '0;
    logic [27:0] rem_left  = '0;
    logic [2:0]  len_cnt   = '0;
    logic [27:0] body_idx  = '0;
    logic [15:0] topic_len = '0;
    logic        pub_ok    = 1'b0;

    t_result tagged_q[$];

    int sent_cnt      = 0;
    int pkt_cnt       = 0;
    int publish_cnt   = 0;
    int connack_cnt   = 0;
    int tagged_cnt    = 0;
    int topic_seen    = 0;
    int payload_seen  = 0;
    int connack_seen  = 0;
    int err_cnt       = 0;
    int burst_left    = 0;
    int stuck_cycles  = 0;
    int rx_mode       = 0;
    int rx_phase_cnt  = 0;
    logic [7:0] rx_pattern = 8'hFF;

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Work out the tag of one received byte and advance the packet state.
    task automatic tag_byte(input logic [7:0] b, output t_result r);
        logic [31:0] past_topic;
        r = '0;
        r.kind = KIND_OTHER;
        r.data_byte = b;
        case (ph)
            PH_HEADER: begin
                cur_type  = b[7:4];
                hdr_flags = b[3:0];
                rem_left  = '0;
                len_cnt   = '0;
                body_idx  = '0;
                topic_len = '0;
                pub_ok    = 1'b0;
                ph        = PH_LENGTH;
                r.kind    = KIND_TYPE;
            end
            PH_LENGTH: begin
                r.kind = KIND_LEN;
                rem_left = rem_left + (28'(b[6:0]) << (LEN_GROUP_BITS * len_cnt[1:0]));
                len_cnt = len_cnt + 3'd1;
                if (!b[7]) begin
                    body_idx = '0;
                    if (rem_left == '0) begin
                        r.last_in_packet = 1'b1;
                        ph = PH_HEADER;
                    end else begin
                        ph = PH_BODY;
                    end
                end else if (len_cnt >= MAX_LENGTH_BYTES) begin
                    ph = PH_BAD;
                end
            end
            PH_BODY: begin
                if (cur_type == PKT_CONNACK) begin
                    if (body_idx == 28'd1) begin
                        r.connack_event = 1'b1;
                        r.connack_code = (b <= CODE_LAST_STD) ? b[2:0] : CODE_UNKNOWN;
                    end
                end else if (cur_type == PKT_PUBLISH) begin
                    if (body_idx == 28'd0) begin
                        topic_len = {b, 8'h00};
                    end else if (body_idx == 28'd1) begin
                        topic_len[7:0] = b;
                        pub_ok = ({4'b0, rem_left} - 32'd1 >= {16'b0, topic_len});
                    end else if (pub_ok) begin
                        past_topic = {4'b0, body_idx} - 32'd2;
                        if (past_topic < {16'b0, topic_len})
                            r.kind = KIND_TOPIC;
                        else if (hdr_flags[2:1] != 2'b00 &&
                                 past_topic - {16'b0, topic_len} < 32'd2)
                            r.kind = KIND_OTHER;
                        else
                            r.kind = KIND_PAYLOAD;
                    end
                end
                rem_left = rem_left - 28'd1;
                body_idx = body_idx + 28'd1;
                if (rem_left == '0) begin
                    r.last_in_packet = 1'b1;
                    ph = PH_HEADER;
                end
            end
            default: r.kind = KIND_OTHER;
        endcase
        r.packet_type = cur_type;
        r.malformed = (ph == PH_BAD);
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        if (err_cnt < MAX_REPORTS)
            $display("[%0t] result %0d: %s got %0d expected %0d", $time, tagged_cnt, what,
                     got, want);
        err_cnt++;
    endtask

    // Send one byte: bursts of random length, random gaps between them.
    task automatic push_byte(input logic [7:0] b);
        t_result want;
        if (burst_left == 0) begin
            repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP)) begin
                @(negedge i_clk);
                in_if.valid = 1'b0;
                in_if.rx_byte = 8'($urandom);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        in_if.valid = 1'b1;
        in_if.rx_byte = b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tag_byte(b, want);
        tagged_q.push_back(want);
        sent_cnt++;
    endtask

    // Header, remaining length (optionally padded with zero groups), then the body.
    task automatic send_packet(input logic [7:0] hdr, input t_byte_q body, input int pad_to);
        logic [6:0] groups[$];
        int len;
        len = body.size();
        groups.push_back(7'(len % 128));
        len = len / 128;
        while (len > 0) begin
            groups.push_back(7'(len % 128));
            len = len / 128;
        end
        while (groups.size() < pad_to) groups.push_back(7'd0);
        push_byte(hdr);
        foreach (groups[i]) push_byte({i < groups.size() - 1, groups[i]});
        foreach (body[i]) push_byte(body[i]);
        pkt_cnt++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (tagged_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed_corners();
        t_byte_q seq;
        seq = '{
            {4'hF, 4'h0}, 8'h00,                                        // empty body
            {PKT_CONNACK, 4'h0}, 8'h02, 8'h01, 8'hFF,                   // unknown code
            {PKT_CONNACK, 4'h0}, 8'h01, 8'h00,                          // no code byte
            {PKT_PUBLISH, 4'h6}, 8'h06, 8'h00, 8'h01, 8'h74, 8'h12, 8'h34, 8'hFF,
            {PKT_PUBLISH, 4'h2}, 8'h03, 8'h00, 8'h05, 8'h61,            // topic overruns
            {PKT_PUBLISH, 4'h0}, 8'h01, 8'h00                           // no topic length
        };
        foreach (seq[i]) push_byte(seq[i]);
    endtask

    task automatic send_random_packet();
        t_byte_q body;
        logic [3:0] ptype;
        logic [3:0] flags;
        logic [15:0] tlen;
        int sel, plen, room, pad;
        sel = $urandom_range(0, 99);
        flags = 4'($urandom);
        ptype = 4'($urandom);
        body = {};
        if (sel < 50) begin
            ptype = PKT_PUBLISH;
            publish_cnt++;
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(0, 1)) body.push_back(8'($urandom));
                1: begin
                    // topic longer than what is left of the body
                    room = $urandom_range(0, 10);
                    tlen = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(room + 1, room + 300)
                                                           : $urandom_range(room + 1, 65535));
                    body.push_back(tlen[15:8]);
                    body.push_back(tlen[7:0]);
                    repeat (room) body.push_back(8'($urandom));
                end
                2: begin
                    // topic fits but packet id or payload may be cut short
                    room = $urandom_range(0, 8);
                    tlen = 16'($urandom_range(0, room));
                    body.push_back(tlen[15:8]);
                    body.push_back(tlen[7:0]);
                    repeat (room) body.push_back(8'($urandom));
                end
                default: begin
                    tlen = 16'($urandom_range(0, 24));
                    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(130, 300)
                                                        : $urandom_range(0, 24);
                    body.push_back(tlen[15:8]);
                    body.push_back(tlen[7:0]);
                    repeat (tlen) body.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    if (flags[2:1] != 2'b00) repeat (2) body.push_back(8'($urandom));
                    repeat (plen) body.push_back(8'($urandom));
                end
            endcase
        end else if (sel < 70) begin
            ptype = PKT_CONNACK;
            connack_cnt++;
            if ($urandom_range(0, 4) != 0) begin
                body.push_back(8'($urandom_range(0, 1)));
                body.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 5))
                                                           : 8'($urandom));
            end else begin
                repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
            end
        end else if (sel < 92) begin
            repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 40)) body.push_back(8'($urandom));
        end
        pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_LENGTH_BYTES) : 1;
        send_packet({ptype, flags}, body, pad);
    endtask

    task automatic test_random_packets();
        int stop_at, next_drain;
        stop_at = sent_cnt + RANDOM_ITEMS;
        next_drain = sent_cnt + DRAIN_EVERY;
        while (sent_cnt < stop_at) begin
            send_random_packet();
            if (sent_cnt >= next_drain) begin
                hold_until_drained();
                next_drain += DRAIN_EVERY;
            end
        end
    endtask

    // Continuation bit on the last allowed length byte; the block stays malformed.
    task automatic test_malformed_length();
        push_byte(8'($urandom));
        repeat (MAX_LENGTH_BYTES) push_byte(8'h80 | 8'($urandom));
        repeat (20) push_byte(8'($urandom));
    endtask

    // receiver: stall mode and pattern are picked anew when the phase counter runs out
    always @(negedge i_clk) begin
        if (rx_phase_cnt == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_pattern = 8'($urandom) | 8'h01;
            rx_phase_cnt = $urandom_range(50, 300);
        end
        rx_phase_cnt--;
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        case (rx_mode)
            0:       out_if.ready = 1'b1;
            1:       out_if.ready = ($urandom_range(0, 3) != 0);
            default: out_if.ready = rx_pattern[0];
        endcase
    end

    always @(posedge i_clk) begin : check_tags
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (tagged_q.size() == 0) begin
                note_mismatch("unexpected result, data_byte", out_if.data_byte, -1);
            end else begin
                want = tagged_q.pop_front();
                if (out_if.byte_kind !== want.kind)
                    note_mismatch("byte_kind", out_if.byte_kind, want.kind);
                if (out_if.packet_type !== want.packet_type)
                    note_mismatch("packet_type", out_if.packet_type, want.packet_type);
                if (out_if.data_byte !== want.data_byte)
                    note_mismatch("data_byte", out_if.data_byte, want.data_byte);
                if (out_if.last_in_packet !== want.last_in_packet)
                    note_mismatch("last_in_packet", out_if.last_in_packet, want.last_in_packet);
                if (out_if.connack_event !== want.connack_event)
                    note_mismatch("connack_event", out_if.connack_event, want.connack_event);
                if (out_if.connack_code !== want.connack_code)
                    note_mismatch("connack_code", out_if.connack_code, want.connack_code);
                if (out_if.malformed !== want.malformed)
                    note_mismatch("malformed", out_if.malformed, want.malformed);
                if (want.kind == KIND_TOPIC) topic_seen++;
                if (want.kind == KIND_PAYLOAD) payload_seen++;
                if (want.connack_event) connack_seen++;
            end
            tagged_cnt++;
        end
    end

    // watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d results outstanding", $time,
                     stuck_cycles, tagged_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.rx_byte = 8'h00;
        out_if.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_random_packets();
        test_malformed_length();

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (tagged_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d tagged bytes over %0d packets (%0d PUBLISH, %0d CONNACK),",
                 tagged_cnt, pkt_cnt, publish_cnt, connack_cnt);
        $display("  %0d topic, %0d payload bytes, %0d return codes, then a broken length field.",
                 topic_seen, payload_seen, connack_seen);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
